### sv/pwg_pkg.sv
// ----------------------------------------------------------------------------
// pwg_pkg
// Shared types and register codes for the trapezoidal pulse generator.
// ----------------------------------------------------------------------------
package pwg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_OFF_LEVEL    = 3'd0,
    REG_ON_LEVEL     = 3'd1,
    REG_START_DELAY  = 3'd2,
    REG_RISE_TICKS   = 3'd3,
    REG_FALL_TICKS   = 3'd4,
    REG_ON_TICKS     = 3'd5,
    REG_PERIOD_TICKS = 3'd6,
    REG_CYCLE_LIMIT  = 3'd7
  } pwg_reg_t;

  // Waveform segment that a sample falls in
  typedef enum logic [1:0] {
    SEG_OFF  = 2'd0,
    SEG_ON   = 2'd1,
    SEG_RISE = 2'd2,
    SEG_FALL = 2'd3
  } pwg_seg_t;

  localparam int CYC_BITS = 17;

endpackage

### sv/pwg_divider.sv
// ----------------------------------------------------------------------------
// pwg_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module pwg_divider #(
  parameter int QUO_BITS = 32,
  parameter int DEN_BITS = 32,
  parameter int SB_BITS  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [DEN_BITS-1:0] in_rem,
  input  logic [QUO_BITS-1:0] in_num,
  input  logic [DEN_BITS-1:0] in_den,
  input  logic [SB_BITS-1:0]  in_sb,
  output logic                out_valid,
  output logic [QUO_BITS-1:0] out_quo,
  output logic [DEN_BITS-1:0] out_rem,
  output logic [SB_BITS-1:0]  out_sb
);

  logic                v_r    [QUO_BITS];
  logic [DEN_BITS-1:0] rem_r  [QUO_BITS];
  logic [QUO_BITS-1:0] word_r [QUO_BITS];
  logic [DEN_BITS-1:0] den_r  [QUO_BITS];
  logic [SB_BITS-1:0]  sb_r   [QUO_BITS];

  logic                src_v    [QUO_BITS];
  logic [DEN_BITS-1:0] src_rem  [QUO_BITS];
  logic [QUO_BITS-1:0] src_word [QUO_BITS];
  logic [DEN_BITS-1:0] src_den  [QUO_BITS];
  logic [SB_BITS-1:0]  src_sb   [QUO_BITS];

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    logic [DEN_BITS:0]   w;
    logic                ge;
    logic [DEN_BITS-1:0] rem_nxt;
    logic [QUO_BITS-1:0] word_nxt;

    if (k == 0) begin : g_first
      assign src_v[k]    = in_valid;
      assign src_rem[k]  = in_rem;
      assign src_word[k] = in_num;
      assign src_den[k]  = in_den;
      assign src_sb[k]   = in_sb;
    end else begin : g_next
      assign src_v[k]    = v_r[k-1];
      assign src_rem[k]  = rem_r[k-1];
      assign src_word[k] = word_r[k-1];
      assign src_den[k]  = den_r[k-1];
      assign src_sb[k]   = sb_r[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
      w        = {src_rem[k], src_word[k][QUO_BITS-1]};
      ge       = (w >= {1'b0, src_den[k]});
      rem_nxt  = ge ? DEN_BITS'(w - {1'b0, src_den[k]}) : w[DEN_BITS-1:0];
      word_nxt = {src_word[k][QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= src_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= rem_nxt;
        word_r[k] <= word_nxt;
        den_r[k]  <= src_den[k];
        sb_r[k]   <= src_sb[k];
      end
    end
  end

  assign out_valid = v_r[QUO_BITS-1];
  assign out_quo   = word_r[QUO_BITS-1];
  assign out_rem   = rem_r[QUO_BITS-1];
  assign out_sb    = sb_r[QUO_BITS-1];

endmodule

### sv/pwg_phase.sv
// ----------------------------------------------------------------------------
// pwg_phase
// Classify a sample by period count and phase; pick ramp position and length.
// ----------------------------------------------------------------------------
module pwg_phase
  import pwg_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_valid,
  input  logic [TIME_BITS-1:0]       in_quo,
  input  logic [TIME_BITS-1:0]       in_rem,
  input  logic                       in_off,
  input  logic [TIME_BITS-1:0]       rise_ticks,
  input  logic [TIME_BITS-1:0]       fall_ticks,
  input  logic [TIME_BITS-1:0]       rise_on_end,
  input  logic [TIME_BITS-1:0]       fall_end,
  input  logic signed [CYC_BITS-1:0] cycle_limit,
  output logic                       out_valid,
  output pwg_seg_t                   out_seg,
  output logic [TIME_BITS-1:0]       out_x,
  output logic [TIME_BITS-1:0]       out_len
);

  localparam int CW = (TIME_BITS > CYC_BITS) ? TIME_BITS : CYC_BITS;

  logic [CW-1:0]        q_ext;
  logic [CW-1:0]        n_ext;
  logic                 beyond;
  logic                 valid_r;
  pwg_seg_t             seg_r, seg_nxt;
  logic [TIME_BITS-1:0] x_r, x_nxt;
  logic [TIME_BITS-1:0] len_r, len_nxt;

  always_comb begin
    q_ext  = CW'(in_quo);
    n_ext  = cycle_limit[CYC_BITS-1] ? CW'(1) : CW'(cycle_limit[CYC_BITS-2:0]);
    beyond = (q_ext > n_ext) || ((q_ext == n_ext) && (in_rem != '0));

    seg_nxt = SEG_OFF;
    x_nxt   = '0;
    len_nxt = TIME_BITS'(1);
    if (in_off || beyond) begin
      seg_nxt = SEG_OFF;
    end else if (in_rem <= rise_ticks) begin
      seg_nxt = (rise_ticks == '0) ? SEG_OFF : SEG_RISE;
      x_nxt   = in_rem;
      len_nxt = (rise_ticks == '0) ? TIME_BITS'(1) : rise_ticks;
    end else if (in_rem < rise_on_end) begin
      seg_nxt = SEG_ON;
    end else if (in_rem < fall_end) begin
      seg_nxt = (fall_ticks == '0) ? SEG_OFF : SEG_FALL;
      x_nxt   = in_rem - rise_on_end;
      len_nxt = (fall_ticks == '0) ? TIME_BITS'(1) : fall_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg_r <= seg_nxt;
      x_r   <= x_nxt;
      len_r <= len_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_seg   = seg_r;
  assign out_x     = x_r;
  assign out_len   = len_r;

  // a ramp never divides by zero and never runs past its length
  a_ramp_len: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (seg_r == SEG_RISE || seg_r == SEG_FALL) |-> len_r != '0 && x_r <= len_r)
    else $error("ramp position outside ramp length");

  a_fall_pos: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && seg_r == SEG_FALL |-> x_r < len_r)
    else $error("fall position reaches fall length");

endmodule

### sv/pulse_waveform_generator_top.sv
// ----------------------------------------------------------------------------
// pulse_waveform_generator_top
// Trapezoidal pulse source evaluated at one sample time per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries a sample time in ticks; each output
// transaction returns the pulse level at that time, in order. The block takes
// one transaction per clock while the output is not stalled. It holds two
// bit-per-stage dividers: the period divider (one stage per time bit) and the
// ramp divider (one stage per level bit). The whole pipeline advances
// together whenever the output register is empty or being taken, so in_ready
// drops only while a finished level waits on out_ready. Write configuration
// only while no transaction is in flight; cfg_ready is always high.
// Pipeline: input register, elapsed time and effective period, period
// divider, phase classification, ramp multiply, ramp divider, output level.
module pulse_waveform_generator_top
  import pwg_pkg::*;
#(
  parameter int TIME_BITS  = 32,
  parameter int LEVEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [TIME_BITS-1:0]         in_sample_time,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [LEVEL_BITS-1:0] out_level,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [((TIME_BITS > LEVEL_BITS) ?
                 ((TIME_BITS > CYC_BITS) ? TIME_BITS : CYC_BITS) :
                 ((LEVEL_BITS > CYC_BITS) ? LEVEL_BITS : CYC_BITS))-1:0] cfg_data
);

  localparam int TB = TIME_BITS;
  localparam int LB = LEVEL_BITS;

  function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a, input logic [TB-1:0] b);
    logic [TB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TB] ? {TB{1'b1}} : s[TB-1:0];
  endfunction

  // Configuration registers
  logic signed [LB-1:0]       off_level_r;
  logic signed [LB-1:0]       on_level_r;
  logic [TB-1:0]              start_delay_r;
  logic [TB-1:0]              rise_ticks_r;
  logic [TB-1:0]              fall_ticks_r;
  logic [TB-1:0]              on_ticks_r;
  logic [TB-1:0]              period_ticks_r;
  logic signed [CYC_BITS-1:0] cycle_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_level_r    <= '0;
      on_level_r     <= '0;
      start_delay_r  <= '0;
      rise_ticks_r   <= '0;
      fall_ticks_r   <= '0;
      on_ticks_r     <= '0;
      period_ticks_r <= '0;
      cycle_limit_r  <= '1;
    end else if (cfg_valid) begin
      unique case (pwg_reg_t'(cfg_index))
        REG_OFF_LEVEL:    off_level_r    <= cfg_data[LB-1:0];
        REG_ON_LEVEL:     on_level_r     <= cfg_data[LB-1:0];
        REG_START_DELAY:  start_delay_r  <= cfg_data[TB-1:0];
        REG_RISE_TICKS:   rise_ticks_r   <= cfg_data[TB-1:0];
        REG_FALL_TICKS:   fall_ticks_r   <= cfg_data[TB-1:0];
        REG_ON_TICKS:     on_ticks_r     <= cfg_data[TB-1:0];
        REG_PERIOD_TICKS: period_ticks_r <= cfg_data[TB-1:0];
        REG_CYCLE_LIMIT:  cycle_limit_r  <= cfg_data[CYC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Phase boundaries, saturating at the largest tick count
  logic [TB-1:0] rise_on_end;
  logic [TB-1:0] fall_end;
  assign rise_on_end = sat_add(rise_ticks_r, on_ticks_r);
  assign fall_end    = sat_add(rise_on_end, fall_ticks_r);

  // Whole pipeline advances when the output slot frees up
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // Stage 1: capture sample time
  logic          s1_valid_r;
  logic [TB-1:0] s1_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_time_r <= in_sample_time;
    end
  end

  // Stage 2: elapsed time, effective period, off before the delay or with no period
  logic          s2_valid_r;
  logic [TB-1:0] s2_elapsed_r;
  logic [TB-1:0] s2_period_r;
  logic          s2_off_r;
  logic [TB-1:0] period_nxt;

  assign period_nxt = (period_ticks_r == '0) ? fall_end : period_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_elapsed_r <= s1_time_r - start_delay_r;
      s2_period_r  <= period_nxt;
      s2_off_r     <= (s1_time_r < start_delay_r) || (period_nxt == '0);
    end
  end

  // Period divider: elapsed / period and elapsed % period
  logic          pd_valid;
  logic [TB-1:0] pd_quo;
  logic [TB-1:0] pd_rem;
  logic          pd_off;

  pwg_divider #(
    .QUO_BITS (TB),
    .DEN_BITS (TB),
    .SB_BITS  (1)
  ) u_period_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s2_valid_r),
    .in_rem    ('0),
    .in_num    (s2_elapsed_r),
    .in_den    (s2_period_r),
    .in_sb     (s2_off_r),
    .out_valid (pd_valid),
    .out_quo   (pd_quo),
    .out_rem   (pd_rem),
    .out_sb    (pd_off)
  );

  // Phase: segment, ramp position and ramp length
  logic          ph_valid;
  pwg_seg_t      ph_seg;
  logic [TB-1:0] ph_x;
  logic [TB-1:0] ph_len;

  pwg_phase #(
    .TIME_BITS (TB)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (pd_valid),
    .in_quo      (pd_quo),
    .in_rem      (pd_rem),
    .in_off      (pd_off),
    .rise_ticks  (rise_ticks_r),
    .fall_ticks  (fall_ticks_r),
    .rise_on_end (rise_on_end),
    .fall_end    (fall_end),
    .cycle_limit (cycle_limit_r),
    .out_valid   (ph_valid),
    .out_seg     (ph_seg),
    .out_x       (ph_x),
    .out_len     (ph_len)
  );

  // Level swing: on - off, its magnitude and direction
  logic signed [LB:0] swing;
  logic [LB:0]        swing_abs;
  logic [LB-1:0]      swing_mag;
  assign swing     = {on_level_r[LB-1], on_level_r} - {off_level_r[LB-1], off_level_r};
  assign swing_abs = swing[LB] ? (LB+1)'(-swing) : swing;
  assign swing_mag = swing_abs[LB-1:0];

  // Stage 4: ramp product |swing| * position
  logic             s4_valid_r;
  logic [LB+TB-1:0] s4_prod_r;
  logic [TB-1:0]    s4_len_r;
  pwg_seg_t         s4_seg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= ph_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_prod_r <= {{TB{1'b0}}, swing_mag} * {{LB{1'b0}}, ph_x};
      s4_len_r  <= ph_len;
      s4_seg_r  <= ph_seg;
    end
  end

  // Ramp divider: product / length, quotient never exceeds |swing|
  logic          rd_valid;
  logic [LB-1:0] rd_quo;
  logic [TB-1:0] rd_rem;
  logic [1:0]    rd_sb;
  pwg_seg_t      rd_seg;

  pwg_divider #(
    .QUO_BITS (LB),
    .DEN_BITS (TB),
    .SB_BITS  (2)
  ) u_ramp_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s4_valid_r),
    .in_rem    (s4_prod_r[LB+TB-1:LB]),
    .in_num    (s4_prod_r[LB-1:0]),
    .in_den    (s4_len_r),
    .in_sb     (s4_seg_r),
    .out_valid (rd_valid),
    .out_quo   (rd_quo),
    .out_rem   (rd_rem),
    .out_sb    (rd_sb)
  );

  assign rd_seg = pwg_seg_t'(rd_sb);

  // Output stage: hold the on or off level, or step away from the ramp start toward its end
  logic signed [LB-1:0] out_level_r;
  logic signed [LB-1:0] level_nxt;
  logic signed [LB-1:0] ramp_from;
  logic                 ramp_up;
  logic [LB:0]          ramp_sum;

  always_comb begin
    ramp_from = (rd_seg == SEG_RISE) ? off_level_r : on_level_r;
    ramp_up   = (rd_seg == SEG_RISE) ? !swing[LB] : swing[LB];
    ramp_sum  = ramp_up ? {ramp_from[LB-1], ramp_from} + {1'b0, rd_quo}
                        : {ramp_from[LB-1], ramp_from} - {1'b0, rd_quo};
    case (rd_seg)
      SEG_ON:   level_nxt = on_level_r;
      SEG_RISE: level_nxt = ramp_sum[LB-1:0];
      SEG_FALL: level_nxt = ramp_sum[LB-1:0];
      default:  level_nxt = off_level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_level_r <= level_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  // plateau and off segments push a zero product through the ramp divider
  a_ramp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid && !(rd_seg == SEG_RISE || rd_seg == SEG_FALL) |-> rd_rem == '0 && rd_quo == '0)
    else $error("non-ramp segment carries a ramp step");

  // a stall freezes the front of the pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_time_r) && $stable(s1_valid_r) && $stable(s2_elapsed_r))
    else $error("pipeline moved during stall");

  // a ramp quotient never exceeds the level swing
  a_ramp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_valid && (rd_seg == SEG_RISE || rd_seg == SEG_FALL) |-> rd_quo <= swing_mag)
    else $error("ramp step beyond swing");

endmodule
